// ===== rtl/sbe_pkg.sv =====
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared types and constants of the stack bytecode executor.
// ----------------------------------------------------------------------------
package sbe_pkg;

   localparam int OP_STACK_DEPTH = 128;
   localparam int HEAP_BYTES = 4096;
   localparam int CALL_STACK_WORDS = 256;
   localparam int OSW = $clog2(OP_STACK_DEPTH);
   localparam int HPW = $clog2(HEAP_BYTES);
   localparam int CSW = $clog2(CALL_STACK_WORDS);

   localparam logic [5:0] OP_HALT = 6'd0;
   localparam logic [5:0] OP_PUSHI8 = 6'd1;
   localparam logic [5:0] OP_PUSHI16 = 6'd2;
   localparam logic [5:0] OP_PUSHL = 6'd3;
   localparam logic [5:0] OP_POPL = 6'd4;
   localparam logic [5:0] OP_PUSHA8 = 6'd5;
   localparam logic [5:0] OP_PUSHA16 = 6'd6;
   localparam logic [5:0] OP_POPA8 = 6'd7;
   localparam logic [5:0] OP_POPA16 = 6'd8;
   localparam logic [5:0] OP_DUP = 6'd9;
   localparam logic [5:0] OP_JZ = 6'd10;
   localparam logic [5:0] OP_JNZ = 6'd11;
   localparam logic [5:0] OP_JMP = 6'd12;
   localparam logic [5:0] OP_CALL = 6'd13;
   localparam logic [5:0] OP_RET = 6'd14;
   localparam logic [5:0] OP_DSP = 6'd15;
   localparam logic [5:0] OP_POP = 6'd16;
   localparam logic [5:0] OP_NEG = 6'd17;
   localparam logic [5:0] OP_LNOT = 6'd18;
   localparam logic [5:0] OP_BNOT = 6'd19;
   localparam logic [5:0] OP_LOR = 6'd20;
   localparam logic [5:0] OP_LAND = 6'd21;
   localparam logic [5:0] OP_BOR = 6'd22;
   localparam logic [5:0] OP_BXOR = 6'd23;
   localparam logic [5:0] OP_BAND = 6'd24;
   localparam logic [5:0] OP_EQ = 6'd25;
   localparam logic [5:0] OP_NE = 6'd26;
   localparam logic [5:0] OP_LT = 6'd27;
   localparam logic [5:0] OP_GT = 6'd28;
   localparam logic [5:0] OP_LE = 6'd29;
   localparam logic [5:0] OP_GE = 6'd30;
   localparam logic [5:0] OP_SHL = 6'd31;
   localparam logic [5:0] OP_SHR = 6'd32;
   localparam logic [5:0] OP_ADD = 6'd33;
   localparam logic [5:0] OP_SUB = 6'd34;
   localparam logic [5:0] OP_MUL = 6'd35;
   localparam logic [5:0] OP_DIV = 6'd36;
   localparam logic [5:0] OP_MOD = 6'd37;
   localparam logic [5:0] OP_HLOAD = 6'd38;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_UNDER = 3'd1;
   localparam logic [2:0] ST_OVER = 3'd2;
   localparam logic [2:0] ST_BADADDR = 3'd3;
   localparam logic [2:0] ST_INVALID = 3'd4;
   localparam logic [2:0] ST_HALTED = 3'd5;
   localparam logic [2:0] ST_DIVZERO = 3'd6;

   // datapath commands, one per controller step
   typedef enum logic [3:0] {
      CMD_NONE   = 4'd0,
      CMD_LATCH  = 4'd1,  // capture item, read top and second
      CMD_READ   = 4'd2,  // read call stack / heap as needed
      CMD_EXEC   = 4'd3,  // compute and commit
      CMD_DIVGO  = 4'd4,  // start divider
      CMD_DIVEND = 4'd5,  // commit divider result
      CMD_ARGCP  = 4'd6,  // copy one call argument, or write the frame link
      CMD_ARGRD  = 4'd7,  // read next argument
      CMD_HEAP2  = 4'd8,  // second heap byte
      CMD_RETRD  = 4'd9,  // load ip from the return ip
      CMD_FIN    = 4'd10  // produce result
   } cmd_type;

   typedef struct packed {
      logic is_div;
      logic is_call;
      logic is_ret;
      logic is_heap16;
      logic err;
      logic arg_left;
      logic div_busy;
   } status_type;

endpackage

// ===== rtl/sbe_divider.sv =====
// ----------------------------------------------------------------------------
// sbe_divider
// Radix-2 restoring divider for unsigned 32-bit magnitudes.
// ----------------------------------------------------------------------------
module sbe_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);
   logic [31:0] q_ff, q_in, r_ff, r_in, d_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] trial;

   always_comb begin
      trial = {r_ff, q_ff[31]} - {1'b0, d_ff};
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      if (start) begin
         q_in = dividend;
         r_in = '0;
         cnt_in = 6'd32;
      end else if (cnt_ff != 6'd0) begin
         cnt_in = cnt_ff - 6'd1;
         if (!trial[32]) begin
            r_in = trial[31:0];
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = {r_ff[30:0], q_ff[31]};
            q_in = {q_ff[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      q_ff <= q_in;
      r_ff <= r_in;
      if (start) d_ff <= divisor;
   end

   assign busy = (cnt_ff != 6'd0);
   assign quotient = q_ff;
   assign remainder = r_ff;
endmodule

// ===== rtl/sbe_datapath.sv =====
// ----------------------------------------------------------------------------
// sbe_datapath
// Stacks, heap, pointers and ALU of the stack bytecode executor.
// ----------------------------------------------------------------------------
module sbe_datapath (
   input  logic                clock,
   input  logic                reset,
   input  sbe_pkg::cmd_type    cmd,
   input  logic [5:0]          req_op,
   input  logic [7:0]          req_imm_byte,
   input  logic [15:0]         req_imm_word,
   output sbe_pkg::status_type stat,
   output logic [15:0]         res_ip,
   output logic [31:0]         res_top,
   output logic [7:0]          res_depth,
   output logic [2:0]          res_status
);
   import sbe_pkg::*;

   localparam int DW = OSW + 1;

   logic [31:0] ostk [OP_STACK_DEPTH];
   logic [31:0] cstk [CALL_STACK_WORDS];
   logic [7:0]  heap [HEAP_BYTES];

   logic [5:0]  op_ff;
   logic [7:0]  ib_ff;
   logic [15:0] iw_ff;
   logic [DW-1:0] dep_ff, dep_in;
   logic [CSW-1:0] sp_ff, sp_in, fp_ff, fp_in;
   logic [15:0] ip_ff, ip_in;
   logic        stop_ff, stop_in;
   logic [31:0] top_ff, sec_ff, cs_rd_ff;
   logic [7:0]  h0_ff, h1_ff;
   logic [2:0]  st_ff, st_in;
   logic [7:0]  argn_ff;
   logic [DW-1:0] argsrc_ff;
   logic [CSW-1:0] argdst_ff;
   logic [31:0] arg_ff;
   logic [15:0] ret_ip_ff;

   // operand stack, call stack and heap write ports
   logic          os_we;
   logic [OSW-1:0] os_wa;
   logic [31:0]   os_wd;
   logic          cs_we;
   logic [CSW-1:0] cs_wa;
   logic [31:0]   cs_wd;
   logic          hp_we;
   logic [HPW-1:0] hp_wa;
   logic [7:0]    hp_wd;

   logic [31:0] alu_r;
   logic [2:0]  ex_st;
   logic        push_op, bin_op, div_op;
   logic [31:0] haddr;
   logic        hbad;
   logic [31:0] mag_a, mag_b;
   logic        div_start, div_busy;
   logic [31:0] dq, dr, div_res;
   logic [31:0] mul_ff;

   sbe_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(mag_a), .divisor(mag_b),
      .busy(div_busy), .quotient(dq), .remainder(dr)
   );

   assign mag_a = sec_ff[31] ? -sec_ff : sec_ff;
   assign mag_b = top_ff[31] ? -top_ff : top_ff;
   assign div_start = (cmd == CMD_DIVGO);

   always_comb begin
      if (op_ff == OP_DIV) div_res = (sec_ff[31] ^ top_ff[31]) ? -dq : dq;
      else div_res = sec_ff[31] ? -dr : dr;
   end

   assign push_op = (op_ff <= OP_PUSHL) || (op_ff == OP_DUP);
   assign bin_op = (op_ff >= OP_LOR) && (op_ff <= OP_MOD);
   assign div_op = (op_ff == OP_DIV) || (op_ff == OP_MOD);
   assign haddr = (op_ff == OP_POPA8 || op_ff == OP_POPA16) ? sec_ff : top_ff;
   always_comb begin
      if (haddr[31]) hbad = 1'b1;
      else if (op_ff == OP_PUSHA16 || op_ff == OP_POPA16)
         hbad = haddr > 32'(HEAP_BYTES - 2);
      else hbad = haddr > 32'(HEAP_BYTES - 1);
   end

   always_comb begin
      case (op_ff)
         OP_NEG:  alu_r = -top_ff;
         OP_LNOT: alu_r = {31'd0, top_ff == 32'd0};
         OP_BNOT: alu_r = ~top_ff;
         OP_LOR:  alu_r = {31'd0, (sec_ff != 0) || (top_ff != 0)};
         OP_LAND: alu_r = {31'd0, (sec_ff != 0) && (top_ff != 0)};
         OP_BOR:  alu_r = sec_ff | top_ff;
         OP_BXOR: alu_r = sec_ff ^ top_ff;
         OP_BAND: alu_r = sec_ff & top_ff;
         OP_EQ:   alu_r = {31'd0, sec_ff == top_ff};
         OP_NE:   alu_r = {31'd0, sec_ff != top_ff};
         OP_LT:   alu_r = {31'd0, $signed(sec_ff) < $signed(top_ff)};
         OP_GT:   alu_r = {31'd0, $signed(sec_ff) > $signed(top_ff)};
         OP_LE:   alu_r = {31'd0, $signed(sec_ff) <= $signed(top_ff)};
         OP_GE:   alu_r = {31'd0, $signed(sec_ff) >= $signed(top_ff)};
         OP_SHL:  alu_r = sec_ff << top_ff[4:0];
         OP_SHR:  alu_r = 32'($signed(sec_ff) >>> top_ff[4:0]);
         OP_ADD:  alu_r = sec_ff + top_ff;
         OP_SUB:  alu_r = sec_ff - top_ff;
         OP_MUL:  alu_r = mul_ff;
         default: alu_r = '0;
      endcase
   end

   // error check for the instruction in op_ff
   always_comb begin
      ex_st = ST_OK;
      if (stop_ff || op_ff == OP_HALT) ex_st = ST_HALTED;
      else if (op_ff > OP_HLOAD) ex_st = ST_INVALID;
      else if (push_op) begin
         if (dep_ff >= DW'(OP_STACK_DEPTH)) ex_st = ST_OVER;
         else if (op_ff == OP_DUP && dep_ff == '0) ex_st = ST_UNDER;
      end else if (op_ff == OP_POPA8 || op_ff == OP_POPA16) begin
         if (dep_ff < DW'(2)) ex_st = ST_UNDER;
         else if (hbad) ex_st = ST_BADADDR;
      end else if (op_ff == OP_JMP || op_ff == OP_RET || op_ff == OP_DSP) ex_st = ST_OK;
      else if (op_ff == OP_CALL) begin
         if ({1'b0, dep_ff} < 9'(ib_ff)) ex_st = ST_UNDER;
      end else if (dep_ff == '0) ex_st = ST_UNDER;
      else if (op_ff == OP_PUSHA8 || op_ff == OP_PUSHA16) begin
         if (hbad) ex_st = ST_BADADDR;
      end else if (bin_op) begin
         if (dep_ff < DW'(2)) ex_st = ST_UNDER;
         else if (div_op && top_ff == 32'd0) ex_st = ST_DIVZERO;
      end
   end

   assign stat.is_div = div_op && (ex_st == ST_OK);
   assign stat.is_call = (op_ff == OP_CALL) && (ex_st == ST_OK);
   assign stat.is_ret = (op_ff == OP_RET) && (ex_st == ST_OK);
   assign stat.is_heap16 = (op_ff == OP_PUSHA16 || op_ff == OP_POPA16) && (ex_st == ST_OK);
   assign stat.err = (ex_st != ST_OK) && (op_ff != OP_HLOAD);
   assign stat.arg_left = (argn_ff != 8'd0);
   assign stat.div_busy = div_busy;

   always_comb begin
      dep_in = dep_ff; sp_in = sp_ff; fp_in = fp_ff; ip_in = ip_ff;
      stop_in = stop_ff; st_in = st_ff;
      os_we = 1'b0; os_wa = '0; os_wd = '0;
      cs_we = 1'b0; cs_wa = '0; cs_wd = '0;
      hp_we = 1'b0; hp_wa = '0; hp_wd = '0;
      unique case (cmd)
         CMD_EXEC: begin
            if (op_ff == OP_HLOAD) begin
               st_in = ST_OK;
               if (iw_ff < 16'(HEAP_BYTES)) begin
                  hp_we = 1'b1; hp_wa = iw_ff[HPW-1:0]; hp_wd = ib_ff;
               end else st_in = ST_BADADDR;
            end else if (ex_st != ST_OK) begin
               st_in = ex_st; stop_in = 1'b1;
            end else begin
               st_in = ST_OK;
               if (push_op) begin
                  os_we = 1'b1; os_wa = dep_ff[OSW-1:0]; dep_in = dep_ff + 1'b1;
                  case (op_ff)
                     OP_PUSHI8:  begin os_wd = {24'd0, ib_ff}; ip_in = ip_ff + 16'd2; end
                     OP_PUSHI16: begin os_wd = {16'd0, iw_ff}; ip_in = ip_ff + 16'd3; end
                     OP_PUSHL:   begin os_wd = cs_rd_ff; ip_in = ip_ff + 16'd2; end
                     default:    begin os_wd = top_ff; ip_in = ip_ff + 16'd1; end
                  endcase
               end else if (op_ff == OP_POPA8 || op_ff == OP_POPA16) begin
                  hp_we = 1'b1; hp_wa = sec_ff[HPW-1:0]; hp_wd = top_ff[7:0];
                  if (op_ff == OP_POPA8) begin
                     dep_in = dep_ff - 1'b1; ip_in = ip_ff + 16'd1;
                  end
               end else if (op_ff == OP_JMP) ip_in = iw_ff;
               else if (op_ff == OP_CALL) begin
                  cs_we = 1'b1; cs_wa = sp_ff; cs_wd = {16'd0, ip_ff + 16'd4};
                  dep_in = dep_ff - DW'(ib_ff);
               end else if (op_ff == OP_RET) begin
                  sp_in = fp_ff - CSW'(2);
                  fp_in = cs_rd_ff[CSW-1:0];
               end else if (op_ff == OP_DSP) begin
                  sp_in = sp_ff + CSW'(ib_ff); ip_in = ip_ff + 16'd2;
               end else if (op_ff == OP_POPL) begin
                  cs_we = 1'b1; cs_wa = fp_ff + CSW'(ib_ff); cs_wd = top_ff;
                  dep_in = dep_ff - 1'b1; ip_in = ip_ff + 16'd2;
               end else if (op_ff == OP_PUSHA8 || op_ff == OP_PUSHA16) begin
                  if (op_ff == OP_PUSHA8) begin
                     os_we = 1'b1; os_wa = dep_ff[OSW-1:0] - 1'b1;
                     os_wd = {24'd0, h0_ff}; ip_in = ip_ff + 16'd1;
                  end
               end else if (op_ff == OP_JZ || op_ff == OP_JNZ) begin
                  dep_in = dep_ff - 1'b1;
                  if ((top_ff == 32'd0) == (op_ff == OP_JZ)) ip_in = iw_ff;
                  else ip_in = ip_ff + 16'd3;
               end else if (op_ff == OP_POP) begin
                  dep_in = dep_ff - 1'b1; ip_in = ip_ff + 16'd1;
               end else if (op_ff <= OP_BNOT) begin
                  os_we = 1'b1; os_wa = dep_ff[OSW-1:0] - 1'b1; os_wd = alu_r;
                  ip_in = ip_ff + 16'd1;
               end else if (!div_op) begin
                  os_we = 1'b1; os_wa = dep_ff[OSW-1:0] - OSW'(2); os_wd = alu_r;
                  dep_in = dep_ff - 1'b1; ip_in = ip_ff + 16'd1;
               end
            end
         end
         CMD_HEAP2: begin
            if (op_ff == OP_POPA16) begin
               hp_we = 1'b1; hp_wa = sec_ff[HPW-1:0] + 1'b1; hp_wd = top_ff[15:8];
               dep_in = dep_ff - 1'b1;
            end else begin
               os_we = 1'b1; os_wa = dep_ff[OSW-1:0] - 1'b1;
               os_wd = {16'd0, h1_ff, h0_ff};
            end
            ip_in = ip_ff + 16'd1;
         end
         CMD_DIVEND: begin
            os_we = 1'b1; os_wa = dep_ff[OSW-1:0] - OSW'(2); os_wd = div_res;
            dep_in = dep_ff - 1'b1; ip_in = ip_ff + 16'd1;
         end
         CMD_ARGCP: begin
            if (argn_ff != 8'd0) begin
               cs_we = 1'b1; cs_wa = argdst_ff; cs_wd = arg_ff;
            end else begin
               // frame link written last
               cs_we = 1'b1; cs_wa = sp_ff + CSW'(1); cs_wd = 32'(fp_ff);
               sp_in = sp_ff + CSW'(2); fp_in = sp_ff + CSW'(2);
               ip_in = iw_ff;
            end
         end
         CMD_RETRD: ip_in = ret_ip_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dep_ff <= '0; sp_ff <= '0; fp_ff <= '0; ip_ff <= '0;
         stop_ff <= 1'b0; st_ff <= ST_OK;
      end else begin
         dep_ff <= dep_in; sp_ff <= sp_in; fp_ff <= fp_in; ip_ff <= ip_in;
         stop_ff <= stop_in; st_ff <= st_in;
      end
   end

   // payload, reads and memories
   always_ff @(posedge clock) begin
      mul_ff <= sec_ff * top_ff;
      if (os_we) ostk[os_wa] <= os_wd;
      if (cs_we) cstk[cs_wa] <= cs_wd;
      if (hp_we) heap[hp_wa] <= hp_wd;
      case (cmd)
         CMD_LATCH: begin
            op_ff <= req_op; ib_ff <= req_imm_byte; iw_ff <= req_imm_word;
            top_ff <= ostk[dep_ff[OSW-1:0] - 1'b1];
            sec_ff <= ostk[dep_ff[OSW-1:0] - OSW'(2)];
         end
         CMD_READ: begin
            if (op_ff == OP_RET) cs_rd_ff <= cstk[fp_ff - CSW'(1)];
            else cs_rd_ff <= cstk[fp_ff + CSW'(ib_ff)];
            h0_ff <= heap[haddr[HPW-1:0]];
            argn_ff <= ib_ff;
            argsrc_ff <= dep_ff - DW'(ib_ff);
            argdst_ff <= sp_ff + CSW'(2);
         end
         CMD_HEAP2: ;
         CMD_ARGRD: arg_ff <= ostk[argsrc_ff[OSW-1:0]];
         CMD_ARGCP: begin
            if (argn_ff != 8'd0) begin
               argn_ff <= argn_ff - 8'd1;
               argsrc_ff <= argsrc_ff + 1'b1;
               argdst_ff <= argdst_ff + 1'b1;
            end
         end
         CMD_EXEC: begin
            h1_ff <= heap[haddr[HPW-1:0] + 1'b1];
            ret_ip_ff <= cstk[fp_ff - CSW'(2)][15:0];
         end
         CMD_FIN: if (dep_ff != '0) res_top <= ostk[dep_ff[OSW-1:0] - 1'b1];
            else res_top <= '0;
         default: ;
      endcase
   end

   assign res_ip = ip_ff;
   assign res_depth = 8'(dep_ff);
   assign res_status = st_ff;
endmodule

// ===== rtl/sbe_control.sv =====
// ----------------------------------------------------------------------------
// sbe_control
// Sequencer issuing datapath commands and running the result handshake.
// ----------------------------------------------------------------------------
module sbe_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   input  sbe_pkg::status_type stat,
   output sbe_pkg::cmd_type    cmd
);
   import sbe_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_READ  = 12'b000000000010,
      S_EXEC  = 12'b000000000100,
      S_DIVGO = 12'b000000001000,
      S_DIVW  = 12'b000000010000,
      S_DIVE  = 12'b000000100000,
      S_ARGRD = 12'b000001000000,
      S_ARGCP = 12'b000010000000,
      S_HEAP2 = 12'b000100000000,
      S_RETRD = 12'b001000000000,
      S_FIN   = 12'b010000000000,
      S_OUT   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = !(state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      cmd = CMD_NONE;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin cmd = CMD_LATCH; state_in = S_READ; end
         S_READ: begin cmd = CMD_READ; state_in = S_EXEC; end
         S_EXEC: begin
            cmd = CMD_EXEC;
            if (stat.is_div) state_in = S_DIVGO;
            else if (stat.is_call) state_in = S_ARGRD;
            else if (stat.is_heap16) state_in = S_HEAP2;
            else if (stat.is_ret) state_in = S_RETRD;
            else state_in = S_FIN;
         end
         S_DIVGO: begin cmd = CMD_DIVGO; state_in = S_DIVW; end
         S_DIVW: if (!stat.div_busy) state_in = S_DIVE;
         S_DIVE: begin cmd = CMD_DIVEND; state_in = S_FIN; end
         S_ARGRD: begin cmd = CMD_ARGRD; state_in = S_ARGCP; end
         S_ARGCP: begin
            cmd = CMD_ARGCP;
            state_in = stat.arg_left ? S_ARGRD : S_FIN;
         end
         S_HEAP2: begin cmd = CMD_HEAP2; state_in = S_FIN; end
         S_RETRD: begin cmd = CMD_RETRD; state_in = S_FIN; end
         S_FIN: begin cmd = CMD_FIN; state_in = S_OUT; end
         S_OUT: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVGO) |=> stat.div_busy) else $error("divider did not start");
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> req_stall) else $error("item taken while result pending");
   a_idle_res: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |=> rsp_valid) else $error("result not raised");
   a_divw: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVW) && !stat.div_busy |=> (state_ff == S_DIVE))
      else $error("divider finish missed");
endmodule

// ===== rtl/stack_bytecode_executor.sv =====
// ----------------------------------------------------------------------------
// stack_bytecode_executor
// Stack-machine instruction executor with operand stack, call stack and heap.
// ----------------------------------------------------------------------------
// Usage: one decoded instruction (req_op, req_imm_byte, req_imm_word) is
// taken on req_valid while req_stall is low. The block then runs a short
// sequence and raises rsp_valid with next ip, top of stack, depth and
// status; the result holds until rsp_stall is low, and only then is the
// next item taken. One item at a time.
// Steps: latch the item with top and second, read call stack and heap,
// execute, then produce the result. A 16-bit heap access adds a second
// heap byte step, a return a return ip step, a call a read and a copy per
// argument (one operand stack read port), divide and modulo a wait on the
// radix-2 divider (one quotient bit per cycle). Reset clears depth,
// pointers, ip and the stopped flag; stack and heap contents are
// undefined until written. After an error or halt every instruction
// answers halted until reset; heap byte loads still work.
// ----------------------------------------------------------------------------
module stack_bytecode_executor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [5:0]  req_op,
   input  logic [7:0]  req_imm_byte,
   input  logic [15:0] req_imm_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_next_ip,
   output logic signed [31:0] rsp_top_value,
   output logic [7:0]  rsp_stack_depth,
   output logic [2:0]  rsp_status
);
   import sbe_pkg::*;

   cmd_type    cmd;
   status_type stat;
   logic [31:0] top;

   sbe_control u_ctl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_stall(rsp_stall), .rsp_valid(rsp_valid), .stat(stat), .cmd(cmd)
   );

   sbe_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req_op(req_op),
      .req_imm_byte(req_imm_byte), .req_imm_word(req_imm_word), .stat(stat),
      .res_ip(rsp_next_ip), .res_top(top), .res_depth(rsp_stack_depth),
      .res_status(rsp_status)
   );

   assign rsp_top_value = $signed(top);
endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the stack bytecode executor. A scoreboard class keeps its
// own copy of the operand stack, call stack, heap and pointers, predicts the
// result of every accepted item and checks the result channel against it.
// A directed sequence comes first, then random programs built so that no
// item reads memory that was never written. One error at the end stops the
// block, and the halted behavior is checked after that.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import sbe_pkg::*;

   localparam int RUN_ITEMS = 1800;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      bit [15:0] next_ip;
      bit [31:0] top_value;
      bit [7:0]  stack_depth;
      bit [2:0]  status;
   } exec_result_type;

   class exec_scoreboard;
      bit [31:0] ostk [OP_STACK_DEPTH];
      int unsigned depth;
      bit [31:0] cstk [CALL_STACK_WORDS];
      bit        cs_written [CALL_STACK_WORDS];
      bit [7:0]  heap [HEAP_BYTES];
      bit        heap_written [HEAP_BYTES];
      int unsigned sp, fp;
      bit [15:0] ip;
      bit        stopped;
      exec_result_type pending [$];
      int errors;
      int checked;

      function int unsigned cs_idx(int unsigned x);
         return x % CALL_STACK_WORDS;
      endfunction

      function bit heap_bad(bit [31:0] addr, int unsigned span);
         return addr[31] || (addr > HEAP_BYTES - span);
      endfunction

      function bit [2:0] alu2(bit [5:0] op, bit [31:0] a, bit [31:0] b,
                              output bit [31:0] r);
         bit [31:0] ma, mb, q, m;
         r = 0;
         case (op)
            OP_LOR:  r = (a != 0 || b != 0);
            OP_LAND: r = (a != 0 && b != 0);
            OP_BOR:  r = a | b;
            OP_BXOR: r = a ^ b;
            OP_BAND: r = a & b;
            OP_EQ:   r = (a == b);
            OP_NE:   r = (a != b);
            OP_LT:   r = ($signed(a) < $signed(b));
            OP_GT:   r = ($signed(a) > $signed(b));
            OP_LE:   r = ($signed(a) <= $signed(b));
            OP_GE:   r = ($signed(a) >= $signed(b));
            OP_SHL:  r = a << b[4:0];
            OP_SHR:  r = $signed(a) >>> b[4:0];
            OP_ADD:  r = a + b;
            OP_SUB:  r = a - b;
            OP_MUL:  r = a * b;
            default: begin
               if (b == 0) return ST_DIVZERO;
               ma = a[31] ? -a : a;
               mb = b[31] ? -b : b;
               q = ma / mb;
               m = ma % mb;
               if (a[31] ^ b[31]) q = -q;
               if (a[31]) m = -m;
               r = (op == OP_DIV) ? q : m;
            end
         endcase
         return ST_OK;
      endfunction

      // true when the item executes cleanly and reads only written memory
      function bit ok(bit [5:0] op, bit [7:0] ib);
         bit [31:0] top, addr;
         top = depth > 0 ? ostk[depth-1] : 0;
         if (op == OP_HLOAD) return 1;
         if (stopped || op == OP_HALT || op > OP_HLOAD) return 0;
         case (op)
            OP_PUSHI8, OP_PUSHI16: return depth < OP_STACK_DEPTH;
            OP_PUSHL: return depth < OP_STACK_DEPTH && cs_written[cs_idx(fp + ib)];
            OP_DUP: return depth >= 1 && depth < OP_STACK_DEPTH;
            OP_POPA8, OP_POPA16: begin
               if (depth < 2) return 0;
               addr = ostk[depth-2];
               return !heap_bad(addr, op == OP_POPA8 ? 1 : 2);
            end
            OP_JMP, OP_DSP: return 1;
            OP_CALL: return depth >= ib;
            OP_RET: return cs_written[cs_idx(fp + CALL_STACK_WORDS - 1)] &&
                           cs_written[cs_idx(fp + CALL_STACK_WORDS - 2)];
            default: begin
               if (depth < 1) return 0;
               case (op)
                  OP_POPL, OP_JZ, OP_JNZ, OP_POP, OP_NEG, OP_LNOT, OP_BNOT: return 1;
                  OP_PUSHA8: return !heap_bad(top, 1) && heap_written[top];
                  OP_PUSHA16: return !heap_bad(top, 2) && heap_written[top] &&
                                     heap_written[top+1];
                  default: begin
                     if (depth < 2) return 0;
                     if ((op == OP_DIV || op == OP_MOD) && top == 0) return 0;
                     return 1;
                  end
               endcase
            end
         endcase
      endfunction

      function void note_input(bit [5:0] op, bit [7:0] ib, bit [15:0] iw);
         bit [2:0] st;
         int unsigned d, base, s;
         bit [31:0] top, v, addr, r;
         bit [16:0] nip;
         exec_result_type e;
         st = ST_OK;
         d = depth;
         top = d > 0 ? ostk[d-1] : 0;
         nip = ip;
         if (op == OP_HLOAD) begin
            if (iw < HEAP_BYTES) begin
               heap[iw] = ib;
               heap_written[iw] = 1;
            end else st = ST_BADADDR;
         end else if (stopped || op == OP_HALT) st = ST_HALTED;
         else if (op > OP_HLOAD) st = ST_INVALID;
         else begin
            case (op)
               OP_PUSHI8, OP_PUSHI16, OP_PUSHL, OP_DUP: begin
                  if (d >= OP_STACK_DEPTH) st = ST_OVER;
                  else if (op == OP_DUP && d < 1) st = ST_UNDER;
                  else begin
                     case (op)
                        OP_PUSHI8:  begin v = ib; nip = ip + 2; end
                        OP_PUSHI16: begin v = iw; nip = ip + 3; end
                        OP_PUSHL:   begin v = cstk[cs_idx(fp + ib)]; nip = ip + 2; end
                        default:    begin v = top; nip = ip + 1; end
                     endcase
                     ostk[d] = v;
                     depth = d + 1;
                  end
               end
               OP_POPA8, OP_POPA16: begin
                  if (d < 2) st = ST_UNDER;
                  else begin
                     addr = ostk[d-2];
                     if (heap_bad(addr, op == OP_POPA8 ? 1 : 2)) st = ST_BADADDR;
                     else begin
                        heap[addr] = top[7:0];
                        heap_written[addr] = 1;
                        if (op == OP_POPA16) begin
                           heap[addr+1] = top[15:8];
                           heap_written[addr+1] = 1;
                        end
                        depth = d - 1;
                        nip = ip + 1;
                     end
                  end
               end
               OP_JMP: nip = iw;
               OP_CALL: begin
                  if (d < ib) st = ST_UNDER;
                  else begin
                     base = d - ib;
                     for (int j = 0; j < ib; j++) begin
                        cstk[cs_idx(sp + 2 + j)] = ostk[base + j];
                        cs_written[cs_idx(sp + 2 + j)] = 1;
                     end
                     depth = base;
                     cstk[cs_idx(sp)] = {16'd0, ip + 16'd4};
                     cstk[cs_idx(sp + 1)] = fp;
                     cs_written[cs_idx(sp)] = 1;
                     cs_written[cs_idx(sp + 1)] = 1;
                     sp = cs_idx(sp + 2);
                     fp = sp;
                     nip = iw;
                  end
               end
               OP_RET: begin
                  s = cs_idx(fp + CALL_STACK_WORDS - 1);
                  fp = cstk[s] % CALL_STACK_WORDS;
                  s = cs_idx(s + CALL_STACK_WORDS - 1);
                  nip = cstk[s][15:0];
                  sp = s;
               end
               OP_DSP: begin
                  sp = cs_idx(sp + ib);
                  nip = ip + 2;
               end
               default: begin
                  if (d < 1) st = ST_UNDER;
                  else begin
                     case (op)
                        OP_POPL: begin
                           cstk[cs_idx(fp + ib)] = top;
                           cs_written[cs_idx(fp + ib)] = 1;
                           depth = d - 1;
                           nip = ip + 2;
                        end
                        OP_PUSHA8, OP_PUSHA16: begin
                           if (heap_bad(top, op == OP_PUSHA8 ? 1 : 2)) st = ST_BADADDR;
                           else begin
                              v = heap[top];
                              if (op == OP_PUSHA16) v[15:8] = heap[top+1];
                              ostk[d-1] = v;
                              nip = ip + 1;
                           end
                        end
                        OP_JZ, OP_JNZ: begin
                           depth = d - 1;
                           if ((top == 0) == (op == OP_JZ)) nip = iw;
                           else nip = ip + 3;
                        end
                        OP_POP: begin
                           depth = d - 1;
                           nip = ip + 1;
                        end
                        OP_NEG, OP_LNOT, OP_BNOT: begin
                           if (op == OP_NEG) v = -top;
                           else if (op == OP_LNOT) v = (top == 0);
                           else v = ~top;
                           ostk[d-1] = v;
                           nip = ip + 1;
                        end
                        default: begin
                           if (d < 2) st = ST_UNDER;
                           else begin
                              st = alu2(op, ostk[d-2], top, r);
                              if (st == ST_OK) begin
                                 ostk[d-2] = r;
                                 depth = d - 1;
                                 nip = ip + 1;
                              end
                           end
                        end
                     endcase
                  end
               end
            endcase
         end
         if (op != OP_HLOAD && st != ST_OK) stopped = 1;
         if (op != OP_HLOAD) ip = nip[15:0];
         e.next_ip = ip;
         e.top_value = depth > 0 ? ostk[depth-1] : 0;
         e.stack_depth = depth[7:0];
         e.status = st;
         pending.push_back(e);
      endfunction

      task report(string msg);
         $display("mismatch @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(bit [15:0] nip, bit [31:0] top, bit [7:0] dep, bit [2:0] st);
         exec_result_type e;
         if (pending.size() == 0) begin
            report("result with no item outstanding");
            return;
         end
         e = pending.pop_front();
         checked++;
         if (nip != e.next_ip)
            report($sformatf("next_ip %h, want %h", nip, e.next_ip));
         if (top != e.top_value)
            report($sformatf("top_value %h, want %h", top, e.top_value));
         if (dep != e.stack_depth)
            report($sformatf("stack_depth %0d, want %0d", dep, e.stack_depth));
         if (st != e.status)
            report($sformatf("status %0d, want %0d", st, e.status));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [5:0]  req_op = 0;
   logic [7:0]  req_imm_byte = 0;
   logic [15:0] req_imm_word = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [15:0] rsp_next_ip;
   logic signed [31:0] rsp_top_value;
   logic [7:0]  rsp_stack_depth;
   logic [2:0]  rsp_status;

   exec_scoreboard sb = new();
   int cyc = 0;
   int sent = 0;
   int burst_left = 0;
   int op_seen [64];

   stack_bytecode_executor dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_op(req_op), .req_imm_byte(req_imm_byte), .req_imm_word(req_imm_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_next_ip(rsp_next_ip), .rsp_top_value(rsp_top_value),
      .rsp_stack_depth(rsp_stack_depth), .rsp_status(rsp_status)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver: phases of no stall, random stall and long stall runs
   always @(posedge clock) begin
      case ((cyc / 97) % 3)
         0: rsp_stall <= 0;
         1: rsp_stall <= $urandom_range(0, 1);
         default: rsp_stall <= (cyc % 23) < 14;
      endcase
   end

   // handshake signals only move at rising edges, so this sees the next edge's values
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_next_ip, rsp_top_value, rsp_stack_depth, rsp_status);
   end

   task send_item(bit [5:0] op, bit [7:0] ib, bit [15:0] iw);
      req_valid <= 1;
      req_op <= op;
      req_imm_byte <= ib;
      req_imm_word <= iw;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      sb.note_input(op, ib, iw);
      op_seen[op]++;
      sent++;
      if (burst_left > 0) burst_left--;
      else begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(0, 8);
      end
   endtask

   // random programs: items that would fault or read unwritten memory are swapped
   task try_send(bit [5:0] op, bit [7:0] ib, bit [15:0] iw);
      if (sb.ok(op, ib)) send_item(op, ib, iw);
      else if (sb.depth < OP_STACK_DEPTH) send_item(OP_PUSHI8, $urandom_range(0, 255), iw);
      else send_item(OP_POP, ib, iw);
   endtask

   task wait_drained();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task random_item();
      int r;
      int lim;
      bit [5:0] op;
      bit [7:0] ib;
      bit [15:0] iw;
      bit [15:0] addr;
      r = $urandom_range(0, 99);
      ib = $urandom_range(0, 255);
      iw = $urandom_range(0, 65535);
      if (r < 10) begin
         // heap store then read back through the address left on the stack
         addr = $urandom_range(0, HEAP_BYTES - 2);
         op = $urandom_range(0, 1) ? OP_POPA16 : OP_POPA8;
         try_send(OP_PUSHI16, ib, addr);
         try_send(OP_PUSHI16, ib, iw);
         try_send(op, ib, iw);
         try_send(op == OP_POPA16 ? OP_PUSHA16 : OP_PUSHA8, ib, iw);
         return;
      end
      if (r < 18) op = OP_HLOAD;
      else if (r < 24) begin
         op = OP_CALL;
         lim = sb.depth < 4 ? sb.depth : 4;
         ib = $urandom_range(0, lim);
      end else if (r < 30) op = OP_RET;
      else if (r < 33) begin
         op = OP_DSP;
         ib = $urandom_range(0, 9) == 0 ? ib : $urandom_range(0, 7);
      end else begin
         op = $urandom_range(OP_PUSHI8, OP_MOD);
         if ((op == OP_PUSHL || op == OP_POPL) && $urandom_range(0, 4) != 0)
            ib = $urandom_range(0, 3);
         if (sb.depth > 110) op = $urandom_range(0, 1) ? OP_POP : OP_ADD;
      end
      if (op == OP_HLOAD && $urandom_range(0, 3) != 0) iw = iw % HEAP_BYTES;
      try_send(op, ib, iw);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: heap loads, 16-bit read, divide and shift corner values, a call frame and jumps
      send_item(OP_HLOAD, 8'hAB, 16'd5);
      send_item(OP_HLOAD, 8'hCD, 16'd6);
      send_item(OP_HLOAD, 8'hFF, 16'hFFFF);
      send_item(OP_PUSHI16, 8'h00, 16'd5);
      send_item(OP_PUSHA16, 8'h00, 16'd0);
      send_item(OP_PUSHI8, 8'hFF, 16'd0);
      send_item(OP_PUSHI8, 8'd1, 16'd0);
      send_item(OP_PUSHI8, 8'd31, 16'd0);
      send_item(OP_SHL, 8'd0, 16'd0);
      send_item(OP_DUP, 8'd0, 16'd0);
      send_item(OP_PUSHI8, 8'd1, 16'd0);
      send_item(OP_NEG, 8'd0, 16'd0);
      send_item(OP_DIV, 8'd0, 16'd0);      // most negative over minus one
      send_item(OP_DUP, 8'd0, 16'd0);
      send_item(OP_PUSHI16, 8'd0, 16'hFFFF);
      send_item(OP_BNOT, 8'd0, 16'd0);
      send_item(OP_MOD, 8'd0, 16'd0);
      send_item(OP_PUSHI16, 8'd0, 16'h0021); // shift count masked
      send_item(OP_SHR, 8'd0, 16'd0);
      send_item(OP_CALL, 8'd2, 16'h1234);
      send_item(OP_PUSHL, 8'd1, 16'd0);
      send_item(OP_POPL, 8'd0, 16'd0);
      send_item(OP_DSP, 8'd3, 16'd0);
      send_item(OP_RET, 8'd0, 16'd0);
      send_item(OP_JZ, 8'd0, 16'hFFFF);
      send_item(OP_JNZ, 8'd0, 16'h8000);
      send_item(OP_JMP, 8'd0, 16'h0000);

      while (sent < RUN_ITEMS) begin
         random_item();
         if (sent > RUN_ITEMS / 2 && sent < RUN_ITEMS / 2 + 6) wait_drained();
      end

      // stop the block with a divide by zero, then check halted answers
      if (sb.depth > OP_STACK_DEPTH - 2) send_item(OP_POP, 8'd0, 16'd0);
      send_item(OP_PUSHI8, 8'd7, 16'd0);
      send_item(OP_PUSHI8, 8'd0, 16'd0);
      send_item(OP_DIV, 8'd0, 16'd0);
      send_item(OP_ADD, 8'd0, 16'd0);
      send_item(OP_HLOAD, 8'h5A, 16'd10);
      send_item(OP_HLOAD, 8'h5A, 16'h1000);
      send_item(6'd63, 8'hFF, 16'hFFFF);
      send_item(OP_HALT, 8'd0, 16'd0);

      wait_drained();
      repeat (60) @(posedge clock);
      $display("%0d items sent, %0d results checked, %0d mismatches", sent, sb.checked,
               sb.errors);
      $display("covered stack, heap, call frames, jumps, alu ops, divide and halted state");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
